// File: rtl/mdt_pkg.sv
// Package for the dependency tokenizer: result and queue types, character codes, scan functions.
`default_nettype none
package mdt_pkg;

  // Character codes that the scanner reacts to.
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChDollar    = 8'h24;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVtab      = 8'h0B;
  localparam logic [7:0] ChFormfeed  = 8'h0C;
  localparam logic [7:0] ChReturn    = 8'h0D;

  // Results one input byte can cause, and queue depth in bundles.
  localparam int MaxRes   = 4;
  localparam int ResIdxW  = $clog2(MaxRes);
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QFillW   = $clog2(QDepth + 1);

  // Lookahead modes of the scanner.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_SEP    = 3'd1,
    MODE_BSL    = 3'd2,
    MODE_DOLLAR = 3'd3,
    MODE_COLON  = 3'd4
  } mode_t;

  // One result item as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       token_end;
    logic       token_discard;
    logic       stream_end;
    logic       last_of_run;
  } result_t;

  // All results of one input byte; last_idx points at the final one.
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [ResIdxW-1:0]   last_idx;
  } bundle_t;

  // Write side of the queue.
  typedef struct packed {
    logic    push;
    bundle_t bundle;
  } q_write_t;

  // Read side of the queue.
  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } q_head_t;

  // Working state while one byte is scanned.
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic [ResCntW-1:0]   count;
    mode_t                mode;
    logic [1:0]           tlen;
    logic                 blank;
  } scan_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChNewline) ||
           (c == ChVtab) || (c == ChFormfeed) || (c == ChReturn);
  endfunction

  // Append a token character as a new result.
  function automatic scan_t emit_char(scan_t s, logic [7:0] c);
    scan_t              r;
    logic [ResIdxW-1:0] k;
    r = s;
    k = r.count[ResIdxW-1:0];
    r.res[k] = '0;
    r.res[k].out_byte = c;
    r.res[k].byte_present = 1'b1;
    r.count = r.count + ResCntW'(1);
    if (r.tlen != 2'd2) begin
      r.tlen = r.tlen + 2'd1;
    end
    if (!is_ws(c)) begin
      r.blank = 1'b0;
    end
    return r;
  endfunction

  // Close the current token, folding the marker into the last character if possible.
  function automatic scan_t emit_end(scan_t s);
    scan_t              r;
    logic [ResIdxW-1:0] k;
    r = s;
    k = ResIdxW'(r.count - ResCntW'(1));
    if (r.count != '0 && r.res[k].byte_present && !r.res[k].token_end) begin
      r.res[k].token_end = 1'b1;
      r.res[k].token_discard = r.blank;
    end else begin
      k = r.count[ResIdxW-1:0];
      r.res[k] = '0;
      r.res[k].token_end = 1'b1;
      r.res[k].token_discard = r.blank;
      r.count = r.count + ResCntW'(1);
    end
    r.tlen = 2'd0;
    r.blank = 1'b1;
    return r;
  endfunction

  // Handle a byte with no lookahead pending.
  function automatic scan_t fresh(scan_t s, logic [7:0] c, logic last);
    scan_t r;
    logic  nonblank;
    r = s;
    nonblank = (r.tlen != 2'd0) && !r.blank;
    if (c == ChColon) begin
      if (nonblank && r.tlen == 2'd1 && !last) begin
        r.mode = MODE_COLON;
      end else if (nonblank) begin
        r = emit_char(r, c);
        r = emit_end(r);
      end else if (r.tlen != 2'd0) begin
        r = emit_end(r);
      end
    end else if (is_ws(c)) begin
      if (nonblank) begin
        r.mode = MODE_SEP;
      end else if (r.tlen != 2'd0) begin
        r = emit_end(r);
      end
    end else if (c == ChBackslash) begin
      if (last) begin
        r = emit_char(r, c);
      end else begin
        r.mode = MODE_BSL;
      end
    end else if (c == ChDollar) begin
      if (last) begin
        r = emit_char(r, c);
      end else begin
        r.mode = MODE_DOLLAR;
      end
    end else begin
      r = emit_char(r, c);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mdt_ifs.sv
// Valid/ready channel interfaces for input bytes and result items.
`default_nettype none
interface mdt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface mdt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       token_end;
  logic       token_discard;
  logic       stream_end;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_present, output token_end,
                  output token_discard, output stream_end, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input byte_present, input token_end,
                input token_discard, input stream_end, input last_of_run,
                output ready);
endinterface
`default_nettype wire

// File: rtl/mdt_front.sv
// Front end: accepts bytes, runs the lookahead scanner and builds a result bundle for each byte that causes results.
`default_nettype none
module mdt_front (
  input  wire logic         clk,
  input  wire logic         rst,
  mdt_in_if.sink            byte_in,
  input  wire logic         q_full,
  output mdt_pkg::q_write_t q_wr
);
  import mdt_pkg::*;

  mode_t              mode;
  logic [1:0]         tlen;
  logic               blank;
  scan_t              s;
  logic [7:0]         c;
  logic               last;
  logic [ResIdxW-1:0] k;
  logic               accept;

  assign byte_in.ready = !q_full;
  assign accept = byte_in.valid && byte_in.ready;

  // Scan one byte against the pending lookahead.
  always_comb begin
    c = byte_in.data_byte;
    last = byte_in.end_of_input;
    s = '0;
    s.mode = MODE_IDLE;
    s.tlen = tlen;
    s.blank = blank;
    unique case (mode)
      MODE_SEP: begin
        if (is_ws(c)) begin
          s.mode = MODE_SEP;
        end else if (c == ChColon) begin
          s = emit_char(s, c);
          s = emit_end(s);
        end else begin
          s = emit_end(s);
          s = fresh(s, c, last);
        end
      end
      MODE_BSL: begin
        if (c == ChBackslash || c == ChHash || c == ChColon || c == ChSpace ||
            c == ChTab) begin
          s = emit_char(s, c);
        end else if (c == ChNewline) begin
          s = fresh(s, c, last);
        end else begin
          s = emit_char(s, ChBackslash);
          s = fresh(s, c, last);
        end
      end
      MODE_DOLLAR: begin
        s = emit_char(s, ChDollar);
        if (c != ChDollar) begin
          s = fresh(s, c, last);
        end
      end
      MODE_COLON: begin
        s = emit_char(s, ChColon);
        if (c != ChSlash && c != ChBackslash) begin
          s = emit_end(s);
        end
        s = fresh(s, c, last);
      end
      default: begin
        s = fresh(s, c, last);
      end
    endcase

    // The final byte flushes any open token and always yields a result.
    if (last) begin
      if (s.tlen != 2'd0) begin
        s = emit_end(s);
      end
      s.mode = MODE_IDLE;
      s.tlen = 2'd0;
      s.blank = 1'b1;
      if (s.count == '0) begin
        s.count = ResCntW'(1);
      end
    end
    k = ResIdxW'(s.count - ResCntW'(1));
    if (last) begin
      s.res[k].stream_end = 1'b1;
    end
    if (s.count != '0) begin
      s.res[k].last_of_run = 1'b1;
    end
  end

  // Bundle into the queue when the byte caused anything.
  always_comb begin
    q_wr.push = accept && (s.count != '0);
    q_wr.bundle.res = s.res;
    q_wr.bundle.last_idx = k;
  end

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      tlen <= 2'd0;
      blank <= 1'b1;
    end else if (accept) begin
      mode <= s.mode;
      tlen <= s.tlen;
      blank <= s.blank;
    end
  end

  a_push_marks_run_end: assert property (@(posedge clk) disable iff (rst)
    q_wr.push |-> q_wr.bundle.res[q_wr.bundle.last_idx].last_of_run)
    else $error("pushed bundle lacks last_of_run on its final result");

  a_last_byte_pushes: assert property (@(posedge clk) disable iff (rst)
    (accept && byte_in.end_of_input) |-> q_wr.push)
    else $error("final byte produced no result");

endmodule
`default_nettype wire

// File: rtl/mdt_queue.sv
// Short bundle queue between the scanner and the result serialiser.
`default_nettype none
module mdt_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mdt_pkg::q_write_t q_wr,
  output logic                   q_full,
  output mdt_pkg::q_head_t       q_head,
  input  wire logic              q_pop
);
  import mdt_pkg::*;

  bundle_t           store [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QFillW-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign q_full = (fill == QFillW'(QDepth));
  assign do_push = q_wr.push && !q_full;
  assign do_pop = q_pop && (fill != '0);

  // Head of the queue goes straight to the serialiser.
  always_comb begin
    q_head.valid = (fill != '0);
    q_head.bundle = store[rd_ptr];
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= q_wr.bundle;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QFillW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QFillW'(1);
      end
    end
  end

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= QFillW'(QDepth))
    else $error("queue fill count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_wr.push)
    else $error("bundle pushed into a full queue");

endmodule
`default_nettype wire

// File: rtl/mdt_back.sv
// Back end: serialises each queued bundle into result items, one per cycle while token_out.ready is high.
`default_nettype none
module mdt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mdt_pkg::q_head_t q_head,
  output logic                  q_pop,
  mdt_out_if.source             token_out
);
  import mdt_pkg::*;

  logic [ResIdxW-1:0] sel;
  logic [ResIdxW-1:0] sel_next;
  result_t            cur;
  logic               fire;

  assign cur = q_head.bundle.res[sel];
  assign fire = token_out.valid && token_out.ready;
  assign q_pop = fire && (sel == q_head.bundle.last_idx);

  // Present the selected result of the head bundle.
  always_comb begin
    token_out.valid = q_head.valid;
    token_out.out_byte = cur.out_byte;
    token_out.byte_present = cur.byte_present;
    token_out.token_end = cur.token_end;
    token_out.token_discard = cur.token_discard;
    token_out.stream_end = cur.stream_end;
    token_out.last_of_run = cur.last_of_run;
  end

  // Step through the bundle; wrap to the first result when it is done.
  always_comb begin
    sel_next = sel;
    if (q_pop) begin
      sel_next = '0;
    end else if (fire) begin
      sel_next = sel + ResIdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else begin
      sel <= sel_next;
    end
  end

  a_sel_in_bundle: assert property (@(posedge clk) disable iff (rst)
    q_head.valid |-> (sel <= q_head.bundle.last_idx))
    else $error("result select runs past the end of the bundle");

endmodule
`default_nettype wire

// File: rtl/makefile_dep_tokenizer_core.sv
// Top level of the Makefile dependency tokenizer.
// Usage: bytes of a dependency file arrive on byte_in (data_byte, end_of_input),
// one request per byte; end_of_input marks the final byte of the file.
// Tokens leave on token_out one character per request: byte_present says a
// character is carried, token_end closes a token (token_discard drops a
// whitespace-only token), last_of_run marks the last result of an input byte
// and stream_end the last result of the file. A byte may cause no result at all.
// Results of a taken byte are registered in the bundle queue before token_out.
// Throughput: one input byte per cycle while the result rate keeps up; each
// byte yields up to two results and token_out drains one per cycle, so the
// output port is the limit. A four-entry bundle queue sits between the
// scanner and the serialiser.
// Stalls: when token_out.ready is low the queue fills; byte_in.ready drops only
// once four bundles are waiting.
// Reset (rst, synchronous): scanner returns to idle between tokens, queue empties.
`default_nettype none
module makefile_dep_tokenizer_core (
  input  wire logic clk,
  input  wire logic rst,
  mdt_in_if.sink    byte_in,
  mdt_out_if.source token_out
);
  import mdt_pkg::*;

  q_write_t q_wr;
  q_head_t  q_head;
  logic     q_full;
  logic     q_pop;

  mdt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  mdt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  mdt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .token_out (token_out)
  );

endmodule
`default_nettype wire
